[sv/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and constants for the first-fit free-list allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

    // fixed field widths of the stream words
    localparam int REQ_W      = 10;
    localparam int ADDR_W     = 10;
    localparam int SLOT_SHIFT = 3;    // headers sit on 8-byte slots
    localparam int RECIP_SH   = 20;   // fraction bits of the align reciprocal

    // request kinds carried in s_tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status carried in m_tuser
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic init_wr;     // write the whole-pool header into slot 0
        logic accept;      // take the input word
        logic calc_q;      // rounding, first half
        logic start_walk;  // rounding, second half; read the list head
        logic advance;     // step to the next free block
        logic capture;     // keep the fitting header and the grant
        logic split_a;     // shrink the block, link the new header
        logic split_b;     // size the new header, relink the predecessor
        logic unlink;      // drop the whole block from the list
        logic out_load;    // move the result into the output register
    } ffa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_short;  // free or zero-size request, no walk
        logic walk_end;    // list ended or visit bound reached
        logic fit;         // current block is large enough
        logic split;       // fitting block leaves enough to split
        logic out_free;    // output register can take a word
    } ffa_stat_t;

endpackage

[sv/ffa_ram.sv]
// ----------------------------------------------------------------------------
// ffa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer for init, request intake, list walk, relink and result hand-off
// ----------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ffa_stat_t stat,
    output ffa_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_INIT    = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_CALC    = 9'b000000100,
        ST_ROUND   = 9'b000001000,
        ST_WALK    = 9'b000010000,
        ST_SPLIT_A = 9'b000100000,
        ST_SPLIT_B = 9'b001000000,
        ST_UNLINK  = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.item_short ? ST_DONE : ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc_q = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.start_walk = 1'b1;
                state_next     = ST_WALK;
            end
            ST_WALK: begin
                priority if (stat.walk_end) begin
                    state_next = ST_DONE;
                end else if (stat.fit) begin
                    cmd.capture = 1'b1;
                    state_next  = stat.split ? ST_SPLIT_A : ST_UNLINK;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_SPLIT_A: begin
                cmd.split_a = 1'b1;
                state_next  = ST_SPLIT_B;
            end
            ST_SPLIT_B: begin
                cmd.split_b = 1'b1;
                state_next  = ST_DONE;
            end
            ST_UNLINK: begin
                cmd.unlink = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    a_walk_leaves_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && stat.walk_end) |=> (state_reg == ST_DONE))
        else $error("walk did not finish on list end");

endmodule

[sv/ffa_dp.sv]
// ----------------------------------------------------------------------------
// ffa_dp
// header stores, list head, walk registers, size rounding and result registers
// ----------------------------------------------------------------------------
module ffa_dp
    import ffa_pkg::*;
#(
    parameter int POOL_BYTES   = 1024,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_command,
    input  logic [REQ_W-1:0]  in_request_size,
    input  logic [ADDR_W-1:0] in_free_address,
    input  ffa_cmd_t          cmd,
    output ffa_stat_t         stat,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [ADDR_W-1:0] out_block_address,
    output logic              out_status
);

    localparam int SLOT_COUNT = POOL_BYTES >> SLOT_SHIFT;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int POOL_W     = SLOT_W + SLOT_SHIFT;
    localparam int SIZE_W     = $clog2(POOL_BYTES);
    localparam int NEED_W     = REQ_W + 1;
    localparam int STEP_W     = $clog2(SLOT_COUNT + 1);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int CW         = ((SIZE_W > NEED_W) ? SIZE_W : NEED_W) + 2;
    localparam int BW         = ((POOL_W > NEED_W) ? POOL_W : NEED_W) + 2;
    localparam int OFF_W      = ((POOL_W > ADDR_W) ? POOL_W : ADDR_W) + 1;
    localparam int ALIGN_W    = $clog2(ALIGN_BYTES + 1);
    localparam int RECIP      = ((1 << RECIP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int RECIP_W    = RECIP_SH + 1;
    localparam int PROD_W     = NEED_W + RECIP_W;

    // walk and request registers
    logic [REQ_W-1:0]           req_reg;
    logic [NEED_W-1:0]          q_reg;
    logic [NEED_W-1:0]          need_reg;
    logic [SLOT_W-1:0]          cur_reg;
    logic                       cv_reg;
    logic [SLOT_W-1:0]          prev_reg;
    logic                       pv_reg;
    logic [STEP_W-1:0]          steps_reg;
    logic [SIZE_W-1:0]          h_size_reg;
    logic [SLOT_W-1:0]          h_next_reg;
    logic                       h_hn_reg;
    logic [SLOT_W-1:0]          head_reg;
    logic                       hv_reg;
    logic [ADDR_W-1:0]          res_addr_reg;
    logic                       res_status_reg;
    logic                       m_valid_reg;
    logic [ADDR_W-1:0]          m_addr_reg;
    logic                       m_status_reg;

    // store ports
    logic                       size_we;
    logic [SLOT_W-1:0]          size_waddr;
    logic [SIZE_W-1:0]          size_wdata;
    logic [SIZE_W-1:0]          rd_size;
    logic                       link_we;
    logic [SLOT_W-1:0]          link_waddr;
    logic [LINK_W-1:0]          link_wdata;
    logic [LINK_W-1:0]          rd_link;
    logic [SLOT_W-1:0]          raddr;
    logic [SLOT_W-1:0]          rd_next;
    logic                       rd_hn;

    // arithmetic
    logic [NEED_W-1:0]          round_x;
    logic [PROD_W-1:0]          recip_prod;
    logic [NEED_W+ALIGN_W-1:0]  need_prod;
    logic [OFF_W-1:0]           free_off;
    logic                       free_ok;
    logic [SLOT_W-1:0]          free_slot;
    logic [BW-1:0]              cur_byte;
    logic [BW-1:0]              grant_byte;
    logic [BW-1:0]              nb_byte;
    logic [SLOT_W-1:0]          nb_slot;
    logic [CW-1:0]              rem_size;

    assign rd_next = rd_link[SLOT_W:1];
    assign rd_hn   = rd_link[0];

    // ceil to alignment: floor by reciprocal, exact for 11-bit operands
    assign round_x    = NEED_W'(req_reg) + NEED_W'(ALIGN_BYTES - 1);
    assign recip_prod = PROD_W'(round_x) * PROD_W'(RECIP);
    assign need_prod  = (NEED_W+ALIGN_W)'(q_reg) * (NEED_W+ALIGN_W)'(ALIGN_BYTES);

    // free request check: on a slot, inside the pool
    assign free_off  = OFF_W'(in_free_address) - OFF_W'(HEADER_BYTES);
    assign free_ok   = (in_free_address >= ADDR_W'(HEADER_BYTES))
                     && (free_off[SLOT_SHIFT-1:0] == '0)
                     && (free_off < OFF_W'(POOL_BYTES));
    assign free_slot = free_off[SLOT_SHIFT +: SLOT_W];

    // grant address and split header slot
    assign cur_byte   = BW'({cur_reg, {SLOT_SHIFT{1'b0}}});
    assign grant_byte = cur_byte + BW'(HEADER_BYTES);
    assign nb_byte    = grant_byte + BW'(need_reg);
    assign nb_slot    = nb_byte[SLOT_SHIFT +: SLOT_W];
    assign rem_size   = CW'(h_size_reg) - CW'(need_reg) - CW'(HEADER_BYTES);

    assign stat.item_short = (in_command == CMD_FREE) || (in_request_size == '0);
    assign stat.walk_end   = !cv_reg || (steps_reg == STEP_W'(SLOT_COUNT));
    assign stat.fit        = CW'(rd_size) >= CW'(need_reg);
    assign stat.split      = CW'(rd_size)
                           > (CW'(HEADER_BYTES) + CW'(ALIGN_BYTES) + CW'(need_reg));
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign raddr = cmd.advance ? rd_next : head_reg;

    always_comb begin
        size_we    = 1'b0;
        size_waddr = cur_reg;
        size_wdata = need_reg[SIZE_W-1:0];
        priority if (cmd.init_wr) begin
            size_we    = 1'b1;
            size_waddr = '0;
            size_wdata = SIZE_W'(POOL_BYTES - HEADER_BYTES);
        end else if (cmd.split_a) begin
            size_we = 1'b1;
        end else if (cmd.split_b) begin
            size_we    = 1'b1;
            size_waddr = nb_slot;
            size_wdata = rem_size[SIZE_W-1:0];
        end else begin
            size_we = 1'b0;
        end
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = prev_reg;
        link_wdata = {h_next_reg, h_hn_reg};
        priority if (cmd.init_wr) begin
            link_we    = 1'b1;
            link_waddr = '0;
            link_wdata = '0;
        end else if (cmd.accept && in_command == CMD_FREE && free_ok) begin
            link_we    = 1'b1;
            link_waddr = free_slot;
            link_wdata = {head_reg, hv_reg};
        end else if (cmd.split_a) begin
            link_we    = 1'b1;
            link_waddr = nb_slot;
        end else if (cmd.split_b) begin
            link_we    = pv_reg;
            link_wdata = {nb_slot, 1'b1};
        end else if (cmd.unlink) begin
            link_we = pv_reg;
        end else begin
            link_we = 1'b0;
        end
    end

    ffa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (SLOT_COUNT)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .raddr (raddr),
        .rdata (rd_size)
    );

    ffa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOT_COUNT)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (rd_link)
    );

    // list head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            hv_reg   <= 1'b1;
        end else begin
            priority if (cmd.accept && in_command == CMD_FREE && free_ok) begin
                head_reg <= free_slot;
                hv_reg   <= 1'b1;
            end else if (cmd.split_b && !pv_reg) begin
                head_reg <= nb_slot;
                hv_reg   <= 1'b1;
            end else if (cmd.unlink && !pv_reg) begin
                head_reg <= h_next_reg;
                hv_reg   <= h_hn_reg;
            end else begin
                head_reg <= head_reg;
            end
        end
    end

    // request, walk and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg        <= in_request_size;
            res_addr_reg   <= '0;
            res_status_reg <= (in_command == CMD_FREE) ? STAT_OK : STAT_FAIL;
        end
        if (cmd.calc_q) begin
            q_reg <= recip_prod[RECIP_SH +: NEED_W];
        end
        if (cmd.start_walk) begin
            need_reg  <= need_prod[NEED_W-1:0];
            cur_reg   <= head_reg;
            cv_reg    <= hv_reg;
            pv_reg    <= 1'b0;
            steps_reg <= '0;
        end
        if (cmd.advance) begin
            prev_reg  <= cur_reg;
            pv_reg    <= 1'b1;
            cur_reg   <= rd_next;
            cv_reg    <= rd_hn;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.capture) begin
            h_size_reg     <= rd_size;
            h_next_reg     <= rd_next;
            h_hn_reg       <= rd_hn;
            res_addr_reg   <= grant_byte[ADDR_W-1:0];
            res_status_reg <= STAT_OK;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid          = m_valid_reg;
    assign out_block_address = m_addr_reg;
    assign out_status        = m_status_reg;

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> (steps_reg < STEP_W'(SLOT_COUNT)))
        else $error("walk stepped past the visit bound");

endmodule

[sv/first_fit_free_list_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// first-fit allocator over a byte pool with a singly linked free list
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one request word per handshake; s_tuser[0] picks allocate (0)
//   or free (1), s_tdata carries the size to allocate and the address to free
//   m_ channel: exactly one result word per request; block_address in
//   m_tdata, status in m_tuser (0 ok, 1 no fit or zero size)
//   free requests and zero-size allocates go from acceptance straight to
//   ST_DONE and reach the output register once it can take a word; an
//   allocate passes ST_CALC, ST_ROUND and ST_WALK, which visits at most
//   POOL_BYTES/8 free blocks, then on a fit ST_SPLIT_A and ST_SPLIT_B for a
//   split or else ST_UNLINK, and ST_DONE; ST_WALK reads one header per cycle
//   one request is worked on at a time; the next is taken once the result
//   sits in the output register, which holds it while m_tready is low
//   after aresetn rises, the init state writes the whole-pool header into
//   slot 0; s_tready stays low during that write
//   POOL_BYTES must be a power of two
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_unit
    import ffa_pkg::*;
#(
    parameter int POOL_BYTES   = 1024,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // request_size [9:0], free_address [19:10], zero pad
    input  logic [0:0]  s_tuser,   // command [0]
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // block_address [9:0], zero pad
    output logic [0:0]  m_tuser    // status [0]
);

    ffa_cmd_t          cmd;
    ffa_stat_t         stat;
    logic [ADDR_W-1:0] block_address;
    logic              status;

    // sequencer: one-hot state machine issuing datapath commands
    ffa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // header stores, list head, walk registers and output register
    ffa_dp #(
        .POOL_BYTES   (POOL_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_command        (s_tuser[0]),
        .in_request_size   (s_tdata[REQ_W-1:0]),
        .in_free_address   (s_tdata[REQ_W +: ADDR_W]),
        .cmd               (cmd),
        .stat              (stat),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_block_address (block_address),
        .out_status        (status)
    );

    assign m_tdata = {{(16 - ADDR_W){1'b0}}, block_address};
    assign m_tuser = status;

    // the header init cycle follows every reset
    a_init_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken during header init");

    // one request in flight at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in flight");

    // a failed allocate never carries an address
    a_fail_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == STAT_FAIL) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("failure word carries a nonzero address");

endmodule

[tb/tb_first_fit_free_list_allocator_unit.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator_unit
// self-checking bench for the first-fit free-list allocator
// ----------------------------------------------------------------------------
// a directed table walks the corner cases: zero size, oversize, exact fit,
// empty list, null and malformed frees, split and no-split boundaries, the
// top of the pool and a double free that closes the list into a loop
// after that, random allocate/free traffic runs in four flow-control phases
// and every result word is compared against a behavioral copy of the free
// list that is updated on each accepted request word
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator_unit
    import ffa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // pool geometry, kept equal to the dut parameters
    localparam int POOL       = 1024;
    localparam int ALIGN      = 8;
    localparam int HDR        = 8;
    localparam int SLOT_B     = 8;
    localparam int SLOTS      = POOL / SLOT_B;

    localparam int PHASE_ITEMS = 220;   // counted words per random phase
    localparam int HOLD_LEN    = 300;   // long receiver hold-off
    localparam int TAIL_LEN    = 150;   // settle time after the last result
    localparam int STUCK_LIMIT = 3000;  // cycles without any handshake
    localparam int PRINT_CAP   = 100;

    typedef enum int {
        PH_STEADY,       // no idling at all
        PH_SRC_GAPS,     // sender may idle before each word, 54 percent odds per draw
        PH_SINK_STALLS,  // receiver stalls 54 of 100, long hold-off first
        PH_BOTH          // both sides at 30 of 100, after a full drain
    } phase_t;

    // one header of the free-list copy
    typedef struct packed {
        logic [9:0] size;
        logic [6:0] link;
        logic       linked;
    } hdr_t;

    // one result word as the bench expects it
    typedef struct packed {
        logic [9:0] addr;
        logic       stat;
    } grant_t;

    typedef struct packed {
        logic       cmd;
        logic [9:0] req;
        logic [9:0] fa;
        logic       typed;   // want is written out below, not predicted
        grant_t     want;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    // directed table, walked in order right after reset
    dir_row_t dir_tab [DIR_ROWS] = '{
        // zero size with every free_address bit set
        '{CMD_ALLOC, 10'd0,    10'd1023, 1'b1, '{10'd0, STAT_FAIL}},
        // largest size rounds to 1024, beyond the whole pool
        '{CMD_ALLOC, 10'd1023, 10'd0,    1'b1, '{10'd0, STAT_FAIL}},
        // exact fit of the whole pool, no split
        '{CMD_ALLOC, 10'd1016, 10'd0,    1'b1, '{10'd8, STAT_OK}},
        // list is now empty
        '{CMD_ALLOC, 10'd1,    10'd0,    1'b1, '{10'd0, STAT_FAIL}},
        // null free, free below the header, misaligned free
        '{CMD_FREE,  10'd1023, 10'd0,    1'b1, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd5,    1'b1, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd13,   1'b1, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd8,    1'b1, '{10'd0, STAT_OK}},
        // smallest size splits the pool
        '{CMD_ALLOC, 10'd1,    10'd0,    1'b0, '{10'd0, STAT_OK}},
        '{CMD_ALLOC, 10'd1000, 10'd0,    1'b0, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd24,   1'b1, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd8,    1'b1, '{10'd0, STAT_OK}},
        '{CMD_ALLOC, 10'd8,    10'd0,    1'b0, '{10'd0, STAT_OK}},
        // leftover equals header plus alignment, whole block unlinked
        '{CMD_ALLOC, 10'd984,  10'd0,    1'b0, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd24,   1'b1, '{10'd0, STAT_OK}},
        // one alignment step less, now it splits near the pool top
        '{CMD_ALLOC, 10'd976,  10'd0,    1'b0, '{10'd0, STAT_OK}},
        '{CMD_ALLOC, 10'd9,    10'd0,    1'b0, '{10'd0, STAT_OK}},
        // double free closes the list on itself
        '{CMD_FREE,  10'd0,    10'd1008, 1'b1, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd1008, 1'b1, '{10'd0, STAT_OK}},
        // walk goes around the loop until the visit bound
        '{CMD_ALLOC, 10'd17,   10'd0,    1'b0, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd24,   1'b1, '{10'd0, STAT_OK}},
        '{CMD_FREE,  10'd0,    10'd8,    1'b1, '{10'd0, STAT_OK}},
        '{CMD_ALLOC, 10'd100,  10'd0,    1'b0, '{10'd0, STAT_OK}},
        '{CMD_ALLOC, 10'd1023, 10'd0,    1'b0, '{10'd0, STAT_OK}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // request_size [9:0], free_address [19:10], zero pad
    logic [0:0]  s_tuser;   // command [0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // block_address [9:0], zero pad
    logic [0:0]  m_tuser;   // status [0]

    // behavioral copy of the header store and list head
    hdr_t       hdr_mem [SLOTS];
    logic [6:0] free_head;
    logic       head_ok;

    grant_t     grant_q [$];   // results still owed by the dut
    logic [9:0] held_q  [$];   // payload offsets handed out and not freed yet
    grant_t     seen_grant;

    int mismatch_count = 0;
    int stuck_cycles   = 0;

    // flow control, set by the stimulus and read by both sides
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_token   = 0;
    int hold_done    = 0;
    int hold_left    = 0;

    first_fit_free_list_allocator_unit #(
        .POOL_BYTES   (POOL),
        .ALIGN_BYTES  (ALIGN),
        .HEADER_BYTES (HDR)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    // first-fit walk over the copy; updates the list and returns the grant
    function automatic grant_t predict_alloc(logic [9:0] req);
        int         need;
        int         steps;
        logic [6:0] cur;
        logic [6:0] prev;
        logic [6:0] succ;
        logic [6:0] nb;
        logic       cur_ok;
        logic       prev_ok;
        logic       succ_ok;
        hdr_t       h;
        grant_t     g;
        g = '{addr: 10'd0, stat: STAT_FAIL};
        if (req == 10'd0)
            return g;
        need    = (int'(req) + ALIGN - 1) / ALIGN * ALIGN;
        cur     = free_head;
        cur_ok  = head_ok;
        prev    = '0;
        prev_ok = 1'b0;
        // the visit bound also ends a walk around a looped list
        for (steps = 0; cur_ok && steps < SLOTS; steps++) begin
            h = hdr_mem[cur];
            if (int'(h.size) >= need) begin
                if (int'(h.size) > HDR + ALIGN + need) begin
                    nb = 7'(((int'(cur) * SLOT_B + HDR + need) / SLOT_B) % SLOTS);
                    hdr_mem[cur].size = 10'(need);
                    hdr_mem[nb] = '{size: 10'(int'(h.size) - need - HDR),
                                    link: h.link, linked: h.linked};
                    succ    = nb;
                    succ_ok = 1'b1;
                end else begin
                    // whole block leaves the list and keeps its size
                    succ    = h.link;
                    succ_ok = h.linked;
                end
                if (prev_ok) begin
                    hdr_mem[prev].link   = succ;
                    hdr_mem[prev].linked = succ_ok;
                end else begin
                    free_head = succ;
                    head_ok   = succ_ok;
                end
                g.addr = 10'(int'(cur) * SLOT_B + HDR);
                g.stat = STAT_OK;
                held_q.push_back(g.addr);
                return g;
            end
            prev    = cur;
            prev_ok = 1'b1;
            cur     = h.link;
            cur_ok  = h.linked;
        end
        return g;
    endfunction

    // push onto the list head; null and malformed offsets change nothing
    function automatic void predict_free(logic [9:0] fa);
        int         off;
        int         i;
        logic [6:0] s;
        if (fa == 10'd0 || int'(fa) < HDR)
            return;
        off = int'(fa) - HDR;
        if (off % SLOT_B != 0 || off >= POOL)
            return;
        s = 7'(off / SLOT_B);
        hdr_mem[s].link   = free_head;
        hdr_mem[s].linked = head_ok;
        free_head = s;
        head_ok   = 1'b1;
        for (i = 0; i < held_q.size(); i++) begin
            if (held_q[i] == fa) begin
                held_q.delete(i);
                break;
            end
        end
    endfunction

    // drive one request word from a falling edge and hold it until taken
    task automatic send_word(logic cmd, logic [9:0] req, logic [9:0] fa,
                             logic typed, grant_t want);
        grant_t g;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, fa, req};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_ALLOC) begin
            g = predict_alloc(req);
        end else begin
            predict_free(fa);
            g = '{addr: 10'd0, stat: STAT_OK};
        end
        if (typed)
            g = want;
        grant_q.push_back(g);
    endtask

    // pick the next random word; noise frees do not count toward the phase
    task automatic pick_word(output logic cmd, output logic [9:0] req,
                             output logic [9:0] fa, output bit counts);
        int r;
        int s;
        r      = $urandom_range(99);
        req    = 10'($urandom);
        fa     = 10'($urandom);
        counts = 1'b1;
        if (r < 5) begin
            // null, below the header, or off the slot grid
            cmd    = CMD_FREE;
            counts = 1'b0;
            s      = $urandom_range(2);
            if (s == 0)
                fa = 10'd0;
            else if (s == 1)
                fa = 10'($urandom_range(7));
            else
                fa = 10'($urandom_range(127) * SLOT_B + $urandom_range(7, 1));
        end else if (r < 47 && held_q.size() != 0) begin
            cmd = CMD_FREE;
            fa  = held_q[$urandom_range(held_q.size() - 1)];
        end else begin
            cmd = CMD_ALLOC;
            s   = $urandom_range(99);
            if (s < 3)
                req = 10'd0;
            else if (s < 15)
                req = 10'($urandom_range(1023, 1));
            else
                req = 10'($urandom_range(96, 1));
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_token != hold_done) begin
                hold_done = hold_token;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("result word with nothing owed, block_address",
                                int'(m_tdata[9:0]), 0);
            end else begin
                seen_grant = grant_q.pop_front();
                if (m_tdata[9:0] !== seen_grant.addr)
                    report_mismatch("block_address", int'(m_tdata[9:0]),
                                    int'(seen_grant.addr));
                if (m_tuser[0] !== seen_grant.stat)
                    report_mismatch("status", int'(m_tuser[0]), int'(seen_grant.stat));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int         i;
        int         k;
        int         done;
        phase_t     ph;
        logic       cmd;
        logic [9:0] req;
        logic [9:0] fa;
        bit         counts;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ALLOC;

        // list copy after reset: one free block over the whole pool
        for (i = 0; i < SLOTS; i++)
            hdr_mem[i] = '{size: 10'd0, link: 7'd0, linked: 1'b0};
        hdr_mem[0].size = 10'(POOL - HDR);
        free_head = 7'd0;
        head_ok   = 1'b1;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i].cmd, dir_tab[i].req, dir_tab[i].fa,
                      dir_tab[i].typed, dir_tab[i].want);

        for (k = 0; k < 4; k++) begin
            ph = phase_t'(k);
            case (ph)
                PH_STEADY: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                PH_SRC_GAPS: begin
                    tx_idle_pct  = 54;
                    rx_stall_pct = 0;
                end
                PH_SINK_STALLS: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 54;
                    // receiver goes quiet while words keep coming, input backs up
                    hold_token++;
                end
                default: begin
                    // sender pauses until every owed result is back
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (grant_q.size() != 0)
                        @(posedge aclk);
                    tx_idle_pct  = 30;
                    rx_stall_pct = 30;
                end
            endcase
            done = 0;
            while (done < PHASE_ITEMS) begin
                pick_word(cmd, req, fa, counts);
                send_word(cmd, req, fa, 1'b0, '{addr: 10'd0, stat: STAT_OK});
                if (counts)
                    done++;
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_LEN) @(posedge aclk);

        if (mismatch_count == 0 && grant_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/ffa_ctrl.sv
sv/ffa_dp.sv
sv/first_fit_free_list_allocator_unit.sv
tb/tb_first_fit_free_list_allocator_unit.sv
